// ===== hw/rtl/rpc_pkg.sv =====
// shared constants and types of the reactive power compensation block
package rpc_pkg;

	// field widths
	localparam int POWER_BITS = 20;
	localparam int COUNT_BITS = 10;
	localparam int SUM_BITS   = 48;
	localparam int PF_BITS    = 16;
	localparam int TAN_BITS   = 16;
	localparam int LEVEL_BITS = 2;

	// fixed point fractions: power factor Q1.15, tangent Q2.14
	localparam int PF_FRAC  = 15;
	localparam int TAN_FRAC = 14;

	// arithmetic unit widths
	localparam int MUL_B_BITS = SUM_BITS + 1;
	localparam int ACC_BITS   = 2 * SUM_BITS + 2;
	localparam int ROOT_BITS  = ACC_BITS / 2;
	localparam int DIV_BITS   = POWER_BITS + COUNT_BITS + PF_BITS;

	localparam logic [TAN_BITS-1:0] TAN_RESET = TAN_BITS'(5381);
	localparam logic [SUM_BITS-1:0] SUM_MAX   = {SUM_BITS{1'b1}};

	// result levels
	localparam logic [LEVEL_BITS-1:0] LEVEL_LOAD    = LEVEL_BITS'(0);
	localparam logic [LEVEL_BITS-1:0] LEVEL_GROUP   = LEVEL_BITS'(1);
	localparam logic [LEVEL_BITS-1:0] LEVEL_INSTALL = LEVEL_BITS'(2);

	// datapath operations
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_MUL_PQ,
		OP_MUL_SPF,
		OP_MUL_DIFF,
		OP_MUL_PSQ,
		OP_MUL_QSQ,
		OP_MUL_TAN,
		OP_WB_P_QTY,
		OP_WB_P_PF,
		OP_DIV,
		OP_WB_S_DIV,
		OP_PF_ZERO,
		OP_SQRT,
		OP_WB_QI,
		OP_QI_ZERO,
		OP_WB_S_ROOT,
		OP_WB_QF,
		OP_EMIT,
		OP_SEL_GROUP,
		OP_SEL_TOTAL
	} dp_op_t;

	typedef struct packed {
		dp_op_t                op;
		logic [LEVEL_BITS-1:0] level;
		logic                  last;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic apparent;
		logic pf_zero;
		logic s_gt_p;
		logic eog;
		logic eoi;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== hw/rtl/rpc_mul.sv =====
// shift-add multiplier with optional accumulate, one multiplier bit per cycle
module rpc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          accumulate,
	input  logic [rpc_pkg::MUL_B_BITS-1:0] a_in,
	input  logic [rpc_pkg::MUL_B_BITS-1:0] b_in,
	output logic                          busy,
	output logic [rpc_pkg::ACC_BITS-1:0]   acc
);
	import rpc_pkg::*;

	logic                  busy_q;
	logic [ACC_BITS-1:0]   a_q;
	logic [MUL_B_BITS-1:0] b_q;
	logic [ACC_BITS-1:0]   acc_q;

	// run until the remaining multiplier bits are all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	// partial product add and shift
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= ACC_BITS'(a_in);
			b_q <= b_in;
			if (!accumulate) begin
				acc_q <= '0;
			end
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

endmodule

// ===== hw/rtl/rpc_sqrt.sv =====
// restoring integer square root, one root bit per cycle
module rpc_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpc_pkg::ACC_BITS-1:0]  radicand,
	output logic                          busy,
	output logic [rpc_pkg::ROOT_BITS-1:0] root
);
	import rpc_pkg::*;

	localparam int CNT_W = $clog2(ROOT_BITS + 1);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ACC_BITS-1:0]    rad_q;
	logic [ROOT_BITS+1:0]   rem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [ROOT_BITS+1:0]   rem_shift;
	logic [ROOT_BITS+1:0]   trial;
	logic [ROOT_BITS+1:0]   rem_diff;
	logic                   fits;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		rem_shift = {rem_q[ROOT_BITS-1:0], rad_q[ACC_BITS-1 -: 2]};
		trial     = {root_q, 2'b01};
		fits      = rem_shift >= trial;
		rem_diff  = rem_shift - trial;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? rem_diff : rem_shift;
			root_q <= {root_q[ROOT_BITS-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== hw/rtl/rpc_datapath.sv =====
// datapath: operand registers, divider, shared multiplier and root unit, sums, output register
module rpc_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rpc_pkg::dp_cmd_t                      cmd,
	output rpc_pkg::dp_status_t                   status,
	input  logic                                  command,
	input  logic [rpc_pkg::POWER_BITS-1:0]        power_value,
	input  logic [rpc_pkg::PF_BITS-1:0]           power_factor,
	input  logic [rpc_pkg::COUNT_BITS-1:0]        quantity,
	input  logic                                  end_of_group,
	input  logic                                  end_of_installation,
	input  logic                                  cfg_we,
	input  logic [rpc_pkg::TAN_BITS-1:0]          cfg_wdata,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [rpc_pkg::LEVEL_BITS-1:0]        level,
	output logic [rpc_pkg::SUM_BITS-1:0]          active_power,
	output logic [rpc_pkg::SUM_BITS-1:0]          apparent_power,
	output logic [rpc_pkg::SUM_BITS-1:0]          reactive_initial,
	output logic [rpc_pkg::SUM_BITS-1:0]          reactive_final,
	output logic signed [rpc_pkg::SUM_BITS:0]     reactive_compensation,
	output logic                                  saturated,
	output logic                                  last
);
	import rpc_pkg::*;

	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	// latched request
	logic                  apparent_q;
	logic [POWER_BITS-1:0] pv_q;
	logic [PF_BITS-1:0]    pf_q;
	logic [COUNT_BITS-1:0] qty_q;
	logic                  eog_q;
	logic                  eoi_q;
	logic [TAN_BITS-1:0]   tan_q;

	// working values
	logic [SUM_BITS-1:0] p_q, s_q, qi_q, qf_q;
	logic                sat_q;

	// running sums
	logic [SUM_BITS-1:0] grp_p_q, grp_q_q, tot_p_q, tot_q_q;

	// output register
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	logic [SUM_BITS-1:0]   out_p_q, out_s_q, out_qi_q, out_qf_q;
	logic [SUM_BITS:0]     out_qc_q;
	logic                  out_sat_q, out_last_q;

	// divider
	logic                  div_busy_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [DIV_BITS-1:0]   div_num_q;
	logic [DIV_BITS-1:0]   div_quo_q;
	logic [PF_BITS-1:0]    div_rem_q;
	logic [PF_BITS:0]      div_shift;
	logic                  div_fits;

	// multiplier and root unit
	logic                  mul_start, mul_accum;
	logic [MUL_B_BITS-1:0] mul_a, mul_b;
	logic                  mul_busy;
	logic [ACC_BITS-1:0]   mul_acc;
	logic                  sqrt_start, sqrt_busy;
	logic [ROOT_BITS-1:0]  sqrt_root;

	// rounded and clamped writebacks
	logic [ACC_BITS-1:0]   p_pf_round, qf_round;
	logic [ACC_BITS-1:0]   p_pf_val, qf_val;
	logic [SUM_BITS:0]     p_qty_c, p_pf_c, s_root_c, qf_c;
	logic [DIV_BITS-1:0]   div_num_init;
	logic                  out_take;

	function automatic logic [SUM_BITS:0] clamp_sum(input logic [ACC_BITS-1:0] v);
		if (v[ACC_BITS-1:SUM_BITS] != '0) begin
			clamp_sum = {1'b1, SUM_MAX};
		end else begin
			clamp_sum = {1'b0, v[SUM_BITS-1:0]};
		end
	endfunction

	function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
			input logic [SUM_BITS-1:0] b);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
	endfunction

	// multiplier operand select
	always_comb begin
		mul_start = 1'b1;
		mul_accum = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (cmd.op)
			OP_MUL_PQ: begin
				mul_a = MUL_B_BITS'(pv_q);
				mul_b = MUL_B_BITS'(qty_q);
			end
			OP_MUL_SPF: begin
				mul_a = MUL_B_BITS'(pv_q);
				mul_b = MUL_B_BITS'(pf_q);
			end
			OP_MUL_DIFF: begin
				mul_a = {1'b0, s_q} - {1'b0, p_q};
				mul_b = {1'b0, s_q} + {1'b0, p_q};
			end
			OP_MUL_PSQ: begin
				mul_a = {1'b0, p_q};
				mul_b = {1'b0, p_q};
			end
			OP_MUL_QSQ: begin
				mul_a     = {1'b0, qi_q};
				mul_b     = {1'b0, qi_q};
				mul_accum = 1'b1;
			end
			OP_MUL_TAN: begin
				mul_a = {1'b0, p_q};
				mul_b = MUL_B_BITS'(tan_q);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign sqrt_start = (cmd.op == OP_SQRT);

	rpc_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mul_start),
		.accumulate(mul_accum),
		.a_in      (mul_a),
		.b_in      (mul_b),
		.busy      (mul_busy),
		.acc       (mul_acc)
	);

	rpc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(mul_acc),
		.busy    (sqrt_busy),
		.root    (sqrt_root)
	);

	// rounding shifts for P from S*pf and for Qf from P*tangent
	always_comb begin
		p_pf_round   = mul_acc + (ACC_BITS'(1) << (PF_FRAC - 1));
		qf_round     = mul_acc + (ACC_BITS'(1) << (TAN_FRAC - 1));
		p_pf_val     = p_pf_round >> PF_FRAC;
		qf_val       = qf_round >> TAN_FRAC;
		p_qty_c      = clamp_sum(mul_acc);
		p_pf_c       = clamp_sum(p_pf_val);
		s_root_c     = clamp_sum(ACC_BITS'(sqrt_root));
		qf_c         = clamp_sum(qf_val);
		div_num_init = (DIV_BITS'(p_q[POWER_BITS+COUNT_BITS-1:0]) << PF_FRAC)
			+ DIV_BITS'(pf_q >> 1);
		div_shift    = {div_rem_q, div_num_q[DIV_BITS-1]};
		div_fits     = div_shift >= {1'b0, pf_q};
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.op == OP_DIV) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= DIV_CNT_W'(DIV_BITS);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			if (div_cnt_q == DIV_CNT_W'(1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	// divider restoring step
	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV) begin
			div_num_q <= div_num_init;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_num_q <= div_num_q << 1;
			div_rem_q <= div_fits ? PF_BITS'(div_shift - {1'b0, pf_q}) : div_shift[PF_BITS-1:0];
			div_quo_q <= {div_quo_q[DIV_BITS-2:0], div_fits};
		end
	end

	// target tangent register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_q <= TAN_RESET;
		end else if (cfg_we) begin
			tan_q <= cfg_wdata;
		end
	end

	// request latch and working values
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				apparent_q <= command;
				pv_q       <= power_value;
				pf_q       <= power_factor;
				qty_q      <= quantity;
				eog_q      <= end_of_group;
				eoi_q      <= end_of_installation;
				sat_q      <= 1'b0;
			end
			OP_WB_P_QTY: begin
				p_q <= p_qty_c[SUM_BITS-1:0];
				if (p_qty_c[SUM_BITS]) begin
					sat_q <= 1'b1;
				end
			end
			OP_WB_P_PF: begin
				s_q <= SUM_BITS'(pv_q);
				p_q <= p_pf_c[SUM_BITS-1:0];
				if (p_pf_c[SUM_BITS]) begin
					sat_q <= 1'b1;
				end
			end
			OP_WB_S_DIV: begin
				s_q <= SUM_BITS'(div_quo_q);
			end
			OP_PF_ZERO: begin
				s_q   <= SUM_MAX;
				qi_q  <= SUM_MAX;
				sat_q <= 1'b1;
			end
			OP_WB_QI: begin
				qi_q <= sqrt_root[SUM_BITS-1:0];
			end
			OP_QI_ZERO: begin
				qi_q <= '0;
			end
			OP_WB_S_ROOT: begin
				s_q <= s_root_c[SUM_BITS-1:0];
				if (s_root_c[SUM_BITS]) begin
					sat_q <= 1'b1;
				end
			end
			OP_WB_QF: begin
				qf_q <= qf_c[SUM_BITS-1:0];
				if (qf_c[SUM_BITS]) begin
					sat_q <= 1'b1;
				end
			end
			OP_SEL_GROUP: begin
				p_q   <= grp_p_q;
				qi_q  <= grp_q_q;
				sat_q <= (grp_p_q == SUM_MAX) || (grp_q_q == SUM_MAX);
			end
			OP_SEL_TOTAL: begin
				p_q   <= tot_p_q;
				qi_q  <= tot_q_q;
				sat_q <= (tot_p_q == SUM_MAX) || (tot_q_q == SUM_MAX);
			end
			default: begin
			end
		endcase
	end

	// group and installation sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_p_q <= '0;
			grp_q_q <= '0;
			tot_p_q <= '0;
			tot_q_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_EMIT: begin
					if (cmd.level == LEVEL_LOAD) begin
						grp_p_q <= sat_add(grp_p_q, p_q);
						grp_q_q <= sat_add(grp_q_q, qi_q);
					end
				end
				OP_SEL_GROUP: begin
					tot_p_q <= sat_add(tot_p_q, grp_p_q);
					tot_q_q <= sat_add(tot_q_q, grp_q_q);
					grp_p_q <= '0;
					grp_q_q <= '0;
				end
				OP_SEL_TOTAL: begin
					tot_p_q <= '0;
					tot_q_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_take = out_valid_q && !out_stall;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_level_q <= cmd.level;
			out_p_q     <= p_q;
			out_s_q     <= s_q;
			out_qi_q    <= qi_q;
			out_qf_q    <= qf_q;
			out_qc_q    <= {1'b0, qi_q} - {1'b0, qf_q};
			out_sat_q   <= sat_q;
			out_last_q  <= cmd.last;
		end
	end

	// status to the controller
	always_comb begin
		status.busy     = mul_busy || sqrt_busy || div_busy_q;
		status.apparent = apparent_q;
		status.pf_zero  = (pf_q == '0);
		status.s_gt_p   = s_q > p_q;
		status.eog      = eog_q;
		status.eoi      = eoi_q;
		status.out_busy = out_valid_q && out_stall;
	end

	assign out_valid             = out_valid_q;
	assign level                 = out_level_q;
	assign active_power          = out_p_q;
	assign apparent_power        = out_s_q;
	assign reactive_initial      = out_qi_q;
	assign reactive_final        = out_qf_q;
	assign reactive_compensation = $signed(out_qc_q);
	assign saturated             = out_sat_q;
	assign last                  = out_last_q;

endmodule

// ===== hw/rtl/rpc_ctrl.sv =====
// controller: sequences the datapath operations for one load and its totals
module rpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rpc_pkg::dp_status_t status,
	output rpc_pkg::dp_cmd_t    cmd
);
	import rpc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_WAIT_P,
		ST_WB_P,
		ST_PF_ZERO,
		ST_DIV,
		ST_WAIT_DIV,
		ST_WB_S,
		ST_CHK_SP,
		ST_WAIT_DIFF,
		ST_SQRT,
		ST_WAIT_SQRT,
		ST_WB_ROOT,
		ST_MUL_QF,
		ST_WAIT_QF,
		ST_WB_QF,
		ST_EMIT,
		ST_SEL_GROUP,
		ST_SEL_TOTAL,
		ST_MUL_PSQ,
		ST_WAIT_PSQ,
		ST_MUL_QSQ,
		ST_WAIT_QSQ
	} state_t;

	state_t                state_q, state_d;
	logic [LEVEL_BITS-1:0] level_q, level_d;
	logic                  more_group, more_total;

	assign more_group = status.eog || status.eoi;
	assign more_total = status.eoi;

	// next state and operation decode
	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		cmd.op    = OP_NOP;
		cmd.level = level_q;
		cmd.last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					level_d = LEVEL_LOAD;
					state_d = ST_MUL_P;
				end
			end
			ST_MUL_P: begin
				cmd.op  = status.apparent ? OP_MUL_SPF : OP_MUL_PQ;
				state_d = ST_WAIT_P;
			end
			ST_WAIT_P: begin
				if (!status.busy) begin
					state_d = ST_WB_P;
				end
			end
			ST_WB_P: begin
				cmd.op = status.apparent ? OP_WB_P_PF : OP_WB_P_QTY;
				priority if (status.apparent) begin
					state_d = ST_CHK_SP;
				end else if (status.pf_zero) begin
					state_d = ST_PF_ZERO;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_PF_ZERO: begin
				cmd.op  = OP_PF_ZERO;
				state_d = ST_MUL_QF;
			end
			ST_DIV: begin
				cmd.op  = OP_DIV;
				state_d = ST_WAIT_DIV;
			end
			ST_WAIT_DIV: begin
				if (!status.busy) begin
					state_d = ST_WB_S;
				end
			end
			ST_WB_S: begin
				cmd.op  = OP_WB_S_DIV;
				state_d = ST_CHK_SP;
			end
			ST_CHK_SP: begin
				if (status.s_gt_p) begin
					cmd.op  = OP_MUL_DIFF;
					state_d = ST_WAIT_DIFF;
				end else begin
					cmd.op  = OP_QI_ZERO;
					state_d = ST_MUL_QF;
				end
			end
			ST_WAIT_DIFF: begin
				if (!status.busy) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.op  = OP_SQRT;
				state_d = ST_WAIT_SQRT;
			end
			ST_WAIT_SQRT: begin
				if (!status.busy) begin
					state_d = ST_WB_ROOT;
				end
			end
			ST_WB_ROOT: begin
				cmd.op  = (level_q == LEVEL_LOAD) ? OP_WB_QI : OP_WB_S_ROOT;
				state_d = ST_MUL_QF;
			end
			ST_MUL_QF: begin
				cmd.op  = OP_MUL_TAN;
				state_d = ST_WAIT_QF;
			end
			ST_WAIT_QF: begin
				if (!status.busy) begin
					state_d = ST_WB_QF;
				end
			end
			ST_WB_QF: begin
				cmd.op  = OP_WB_QF;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.op = OP_EMIT;
					priority if (level_q == LEVEL_LOAD && more_group) begin
						level_d = LEVEL_GROUP;
						state_d = ST_SEL_GROUP;
					end else if (level_q == LEVEL_GROUP && more_total) begin
						level_d = LEVEL_INSTALL;
						state_d = ST_SEL_TOTAL;
					end else begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_SEL_GROUP: begin
				cmd.op  = OP_SEL_GROUP;
				state_d = ST_MUL_PSQ;
			end
			ST_SEL_TOTAL: begin
				cmd.op  = OP_SEL_TOTAL;
				state_d = ST_MUL_PSQ;
			end
			ST_MUL_PSQ: begin
				cmd.op  = OP_MUL_PSQ;
				state_d = ST_WAIT_PSQ;
			end
			ST_WAIT_PSQ: begin
				if (!status.busy) begin
					state_d = ST_MUL_QSQ;
				end
			end
			ST_MUL_QSQ: begin
				cmd.op  = OP_MUL_QSQ;
				state_d = ST_WAIT_QSQ;
			end
			ST_WAIT_QSQ: begin
				if (!status.busy) begin
					state_d = ST_SQRT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= LEVEL_LOAD;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/reactive_power_compensation_core.sv =====
// top level of the reactive power compensation block
// the time from request to last result, plus any output stalls, is set by the
// shift-add multiplier (one bit per cycle), the 46-step divider and the 49-step square root
// throughput: one request at a time; the next is taken once its last result is registered
// reset: arst_n clears the sums, the controller and the output valid; tangent returns to 5381
module reactive_power_compensation_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [rpc_pkg::POWER_BITS-1:0]      power_value,
	input  logic [rpc_pkg::PF_BITS-1:0]         power_factor,
	input  logic [rpc_pkg::COUNT_BITS-1:0]      quantity,
	input  logic                                end_of_group,
	input  logic                                end_of_installation,
	input  logic                                cfg_we,
	input  logic [rpc_pkg::TAN_BITS-1:0]        cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rpc_pkg::LEVEL_BITS-1:0]      level,
	output logic [rpc_pkg::SUM_BITS-1:0]        active_power,
	output logic [rpc_pkg::SUM_BITS-1:0]        apparent_power,
	output logic [rpc_pkg::SUM_BITS-1:0]        reactive_initial,
	output logic [rpc_pkg::SUM_BITS-1:0]        reactive_final,
	output logic signed [rpc_pkg::SUM_BITS:0]   reactive_compensation,
	output logic                                saturated,
	output logic                                last
);
	import rpc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	rpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	rpc_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.command              (command),
		.power_value          (power_value),
		.power_factor         (power_factor),
		.quantity             (quantity),
		.end_of_group         (end_of_group),
		.end_of_installation  (end_of_installation),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.level                (level),
		.active_power         (active_power),
		.apparent_power       (apparent_power),
		.reactive_initial     (reactive_initial),
		.reactive_final       (reactive_final),
		.reactive_compensation(reactive_compensation),
		.saturated            (saturated),
		.last                 (last)
	);

	// a taken request keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted but block not busy");

	// a stalled result stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level) && $stable(active_power)
			&& $stable(last))
		else $error("stalled result changed");

	// installation totals always close the request
	a_install_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level == LEVEL_INSTALL |-> last)
		else $error("installation totals without last");

	// compensation is initial minus final reactive power
	a_qc_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reactive_compensation ==
			($signed({1'b0, reactive_initial}) - $signed({1'b0, reactive_final})))
		else $error("compensation mismatch");

endmodule

// ===== tb/reactive_power_compensation_core_tb.sv =====
// testbench of the reactive power compensation block: per-load, group and installation results
`timescale 1ns / 100ps

module reactive_power_compensation_core_tb;
	import rpc_pkg::*;

	// one load request
	typedef struct {
		logic                  cmd;
		logic [POWER_BITS-1:0] pv;
		logic [PF_BITS-1:0]    pf;
		logic [COUNT_BITS-1:0] qty;
		logic                  eog;
		logic                  eoi;
	} load_req_t;

	// one power figure result
	typedef struct {
		logic [LEVEL_BITS-1:0] lvl;
		logic [SUM_BITS-1:0]   p;
		logic [SUM_BITS-1:0]   s;
		logic [SUM_BITS-1:0]   qi;
		logic [SUM_BITS-1:0]   qf;
		logic [SUM_BITS:0]     qc;
		logic                  sat;
		logic                  lst;
	} power_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic [POWER_BITS-1:0] power_value = '0;
	logic [PF_BITS-1:0] power_factor = '0;
	logic [COUNT_BITS-1:0] quantity = '0;
	logic end_of_group = 1'b0;
	logic end_of_installation = 1'b0;
	logic cfg_we = 1'b0;
	logic [TAN_BITS-1:0] cfg_wdata = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [LEVEL_BITS-1:0] level;
	logic [SUM_BITS-1:0] active_power;
	logic [SUM_BITS-1:0] apparent_power;
	logic [SUM_BITS-1:0] reactive_initial;
	logic [SUM_BITS-1:0] reactive_final;
	logic signed [SUM_BITS:0] reactive_compensation;
	logic saturated;
	logic last;

	reactive_power_compensation_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .power_value(power_value), .power_factor(power_factor),
		.quantity(quantity), .end_of_group(end_of_group),
		.end_of_installation(end_of_installation),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.level(level), .active_power(active_power), .apparent_power(apparent_power),
		.reactive_initial(reactive_initial), .reactive_final(reactive_final),
		.reactive_compensation(reactive_compensation),
		.saturated(saturated), .last(last)
	);

	always #5 clk = ~clk;

	load_req_t     pending_loads[$];
	power_result_t expected_results[$];
	logic [TAN_BITS-1:0] tangent = TAN_RESET;
	logic [SUM_BITS-1:0] grp_p_sum = '0, grp_q_sum = '0, tot_p_sum = '0, tot_q_sum = '0;
	int  queued_cnt = 0;
	int  accepted_cnt = 0;
	int  error_cnt = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;

	// integer square root, floor
	function automatic logic [63:0] isqrt(logic [127:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [SUM_BITS-1:0] clamp_sum(logic [127:0] v, inout logic sat);
		if (v > {{(128-SUM_BITS){1'b0}}, SUM_MAX}) begin
			sat = 1'b1;
			return SUM_MAX;
		end
		return v[SUM_BITS-1:0];
	endfunction

	function automatic logic [SUM_BITS-1:0] sum_add(logic [SUM_BITS-1:0] a, logic [SUM_BITS-1:0] b);
		logic [SUM_BITS:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[SUM_BITS] ? SUM_MAX : t[SUM_BITS-1:0];
	endfunction

	// reactive power left after correction, P times tangent
	function automatic logic [SUM_BITS-1:0] corrected_reactive(logic [SUM_BITS-1:0] p,
			inout logic sat);
		logic [127:0] w;
		w = ({80'd0, p} * {112'd0, tangent} + 128'd8192) >> TAN_FRAC;
		return clamp_sum(w, sat);
	endfunction

	function automatic logic [SUM_BITS-1:0] reactive_of(logic [SUM_BITS-1:0] s,
			logic [SUM_BITS-1:0] p);
		if (s <= p)
			return '0;
		return SUM_BITS'(isqrt({80'd0, s} * {80'd0, s} - {80'd0, p} * {80'd0, p}));
	endfunction

	function automatic void push_result(logic [LEVEL_BITS-1:0] lvl, logic [SUM_BITS-1:0] p,
			logic [SUM_BITS-1:0] s, logic [SUM_BITS-1:0] qi, logic [SUM_BITS-1:0] qf,
			logic sat);
		power_result_t r;
		r.lvl = lvl;
		r.p = p;
		r.s = s;
		r.qi = qi;
		r.qf = qf;
		r.qc = {1'b0, qi} - {1'b0, qf};
		r.sat = sat;
		r.lst = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void push_totals(logic [LEVEL_BITS-1:0] lvl, logic [SUM_BITS-1:0] p,
			logic [SUM_BITS-1:0] q);
		logic sat;
		logic [SUM_BITS-1:0] s, qf;
		sat = (p == SUM_MAX) || (q == SUM_MAX);
		s = clamp_sum({64'd0, isqrt({80'd0, p} * {80'd0, p} + {80'd0, q} * {80'd0, q})}, sat);
		qf = corrected_reactive(p, sat);
		push_result(lvl, p, s, q, qf, sat);
	endfunction

	// expected results of one accepted load request
	function automatic void predict_load(load_req_t ld);
		logic sat;
		logic [SUM_BITS-1:0] p, s, qi, qf;
		sat = 1'b0;
		if (ld.cmd == 1'b0) begin
			p = clamp_sum({98'd0, ld.pv} * {118'd0, ld.qty}, sat);
			if (ld.pf == '0) begin
				s = SUM_MAX;
				qi = SUM_MAX;
				sat = 1'b1;
			end else begin
				s = clamp_sum(({80'd0, p} * 128'd32768 + {112'd0, ld.pf >> 1}) / {112'd0, ld.pf},
					sat);
				qi = reactive_of(s, p);
			end
		end else begin
			s = clamp_sum({108'd0, ld.pv}, sat);
			p = clamp_sum(({80'd0, s} * {112'd0, ld.pf} + 128'd16384) >> PF_FRAC, sat);
			qi = reactive_of(s, p);
		end
		qf = corrected_reactive(p, sat);
		push_result(LEVEL_LOAD, p, s, qi, qf, sat);
		grp_p_sum = sum_add(grp_p_sum, p);
		grp_q_sum = sum_add(grp_q_sum, qi);
		if (ld.eog || ld.eoi) begin
			push_totals(LEVEL_GROUP, grp_p_sum, grp_q_sum);
			tot_p_sum = sum_add(tot_p_sum, grp_p_sum);
			tot_q_sum = sum_add(tot_q_sum, grp_q_sum);
			grp_p_sum = '0;
			grp_q_sum = '0;
		end
		if (ld.eoi) begin
			push_totals(LEVEL_INSTALL, tot_p_sum, tot_q_sum);
			tot_p_sum = '0;
			tot_q_sum = '0;
		end
		expected_results[expected_results.size()-1].lst = 1'b1;
	endfunction

	// gap or stall length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 94)
			return $urandom_range(1, 4);
		return $urandom_range(20, 70);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		load_req_t ld;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_load('{command, power_value, power_factor, quantity,
					end_of_group, end_of_installation});
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_loads.size() != 0) begin
					ld = pending_loads.pop_front();
					command <= ld.cmd;
					power_value <= ld.pv;
					power_factor <= ld.pf;
					quantity <= ld.qty;
					end_of_group <= ld.eog;
					end_of_installation <= ld.eoi;
					in_valid <= 1'b1;
					gap_left <= idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_cnt++;
		end
	endtask

	// result monitor with random stall and one long hold
	always @(posedge clk or negedge arst_n) begin
		power_result_t r;
		if (!arst_n) begin
			out_stall <= 1'b1;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, level %0d", $time, level);
					error_cnt++;
				end else begin
					r = expected_results.pop_front();
					check_field("level", 64'(r.lvl), 64'(level));
					check_field("active_power", 64'(r.p), 64'(active_power));
					check_field("apparent_power", 64'(r.s), 64'(apparent_power));
					check_field("reactive_initial", 64'(r.qi), 64'(reactive_initial));
					check_field("reactive_final", 64'(r.qf), 64'(reactive_final));
					check_field("reactive_compensation", 64'(r.qc),
						64'($unsigned(reactive_compensation)));
					check_field("saturated", 64'(r.sat), 64'(saturated));
					check_field("last", 64'(r.lst), 64'(last));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 400;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= idle_len();
			end
		end
	end

	task automatic queue_load(logic cmd, logic [POWER_BITS-1:0] pv, logic [PF_BITS-1:0] pf,
			logic [COUNT_BITS-1:0] qty, logic eog, logic eoi);
		pending_loads.push_back('{cmd, pv, pf, qty, eog, eoi});
		queued_cnt++;
	endtask

	// random installation made of groups of loads
	task automatic queue_random(int n);
		int grp_len;
		int k;
		logic [PF_BITS-1:0] pf;
		grp_len = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: pf = PF_BITS'($urandom_range(0, 65535));
				1: pf = PF_BITS'($urandom_range(0, 2));
				2: pf = PF_BITS'(32768);
				default: pf = PF_BITS'($urandom_range(1000, 32768));
			endcase
			grp_len--;
			queue_load(1'($urandom_range(0, 1)), POWER_BITS'($urandom()), pf,
				($urandom_range(0, 19) == 0) ? COUNT_BITS'(0) : COUNT_BITS'($urandom()),
				grp_len == 0 || $urandom_range(0, 15) == 0,
				(grp_len == 0 && $urandom_range(0, 2) == 0) || k == n - 1);
			if (grp_len <= 0)
				grp_len = $urandom_range(1, 6);
		end
	endtask

	// every request taken and every result seen, then let the block settle
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_tangent(logic [TAN_BITS-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tangent = v;
	endtask

	// stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed loads at the reset tangent
		queue_load(1'b0, '0, PF_BITS'(32768), COUNT_BITS'(1), 1'b0, 1'b0);
		queue_load(1'b0, '1, PF_BITS'(32768), '1, 1'b0, 1'b0);
		queue_load(1'b0, '1, PF_BITS'(1), '1, 1'b1, 1'b0);
		queue_load(1'b0, POWER_BITS'(1000), PF_BITS'(26214), COUNT_BITS'(0), 1'b0, 1'b0);
		queue_load(1'b1, POWER_BITS'(5000), '0, COUNT_BITS'(7), 1'b0, 1'b0);
		queue_load(1'b1, '1, '1, '0, 1'b0, 1'b0);
		queue_load(1'b0, POWER_BITS'(2000), PF_BITS'(40000), COUNT_BITS'(3), 1'b0, 1'b1);
		queue_load(1'b1, '1, PF_BITS'(32768), '1, 1'b1, 1'b1);
		queue_load(1'b1, POWER_BITS'(12345), PF_BITS'(1), COUNT_BITS'(1), 1'b0, 1'b1);
		// zero power factor saturates, sums stick at the maximum
		queue_load(1'b0, POWER_BITS'(100), '0, COUNT_BITS'(2), 1'b0, 1'b0);
		queue_load(1'b0, POWER_BITS'(300), PF_BITS'(20000), COUNT_BITS'(5), 1'b1, 1'b0);
		queue_load(1'b0, POWER_BITS'(50), '0, COUNT_BITS'(1), 1'b1, 1'b0);
		queue_load(1'b1, POWER_BITS'(800), PF_BITS'(16384), '0, 1'b0, 1'b1);
		queue_load(1'b0, POWER_BITS'(7), PF_BITS'(65535), COUNT_BITS'(9), 1'b0, 1'b0);
		queue_load(1'b1, POWER_BITS'(1), PF_BITS'(32767), COUNT_BITS'(512), 1'b1, 1'b1);
		queue_load(1'b0, POWER_BITS'(524288), PF_BITS'(16384), COUNT_BITS'(512), 1'b0, 1'b1);
		wait_idle();

		// maximum tangent, with a long receiver hold so the block backs up
		write_tangent('1);
		hold_req = 1'b1;
		queue_load(1'b0, '1, PF_BITS'(100), '1, 1'b1, 1'b1);
		queue_random(60);
		wait_idle();

		// zero tangent, no idling at either side
		write_tangent('0);
		calm = 1'b1;
		queue_random(60);
		wait_idle();
		calm = 1'b0;

		write_tangent(TAN_BITS'(16384));
		queue_random(60);
		wait_idle();

		write_tangent(TAN_BITS'($urandom()));
		queue_random(60);
		wait_idle();

		if (error_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run time limit
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
